[hw/rtl/dfc_pkg.sv]
// ----------------------------------------------------------------------------
// dfc_pkg: shared types and constants of the decimating FIR filter
// Payload structs, register codes, arithmetic widths, control bundles.
// ----------------------------------------------------------------------------
package dfc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH    = 64;

  localparam int DEF_MAX_TAPS   = 64;
  localparam int DEF_MAX_FACTOR = 64;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam int TAP_COUNT_W  = 7;
  localparam int FACTOR_W     = 7;
  localparam int COEF_INDEX_W = 6;
  localparam int SHIFT_W      = 5;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(1);
  localparam logic [FACTOR_W-1:0]    FACTOR_RST    = FACTOR_W'(1);
  localparam logic [SHIFT_W-1:0]     SHIFT_RST     = SHIFT_W'(15);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TAP_COUNT    = 3'd0,
    REG_DECIM_FACTOR = 3'd1,
    REG_COMPLEX_MODE = 3'd2,
    REG_COEF_INDEX   = 3'd3,
    REG_COEF_VALUE   = 3'd4,
    REG_OUT_SHIFT    = 3'd5
  } dfc_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
  } dfc_sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;
    logic                           saturated;
  } dfc_result_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } dfc_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic vld;
    logic last;
  } dfc_mac_ctrl_t;

  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[hw/rtl/decimating_fir_filter_core.sv]
// ----------------------------------------------------------------------------
// decimating_fir_filter_core: decimating FIR filter, real or complex samples
// Samples enter a chain of tap cells; each output is a dot product of the
// newest tap_count samples with the coefficient RAM, rounded and saturated.
//
// Sample channel (sample_valid/sample_stall/sample) takes one request per
// cycle while no output is being computed. A request that completes a
// decimation period starts a pass: the tap chain rotates once through all
// MAX_TAPS cells past a single multiply-accumulate unit, then the sum is
// rounded and saturated. sample_stall stays high from such a request until
// the sum is taken into the result register and result_valid rises; no
// new sample is taken before then. Other samples go one a cycle.
// The result register holds its request while result_stall is high; the
// next sample may be taken meanwhile, and a following pass waits at its end
// until the register is free.
// Configuration is to be written over APB only while idle; the block itself
// does not enforce this. pready is always high.
// Reset clears the counters and registers (out_shift to 15); delay line and
// coefficient RAM keep whatever they hold and need no clearing pass.
// ----------------------------------------------------------------------------
module decimating_fir_filter_core #(
  parameter int MAX_TAPS   = dfc_pkg::DEF_MAX_TAPS,
  parameter int MAX_FACTOR = dfc_pkg::DEF_MAX_FACTOR
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  dfc_pkg::dfc_sample_t              sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output dfc_pkg::dfc_result_t              result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dfc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dfc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dfc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import dfc_pkg::*;

  localparam int CAW = addr_w(MAX_TAPS);
  localparam int FW  = $clog2(MAX_TAPS + 1);
  localparam int PW  = addr_w(MAX_FACTOR);

  logic [TAP_COUNT_W-1:0]  tap_count;
  logic [FACTOR_W-1:0]     decim_factor;
  logic                    complex_mode;
  logic [COEF_INDEX_W-1:0] coef_index;
  logic [COEF_WIDTH-1:0]   coef_value;
  logic [SHIFT_W-1:0]      out_shift;

  logic                    wr_en;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    coef_we;

  logic [FW-1:0]           fill_count, fill_count_next;
  logic [PW-1:0]           phase_count, phase_count_next;
  logic [FW-1:0]           taps_eff;
  logic [PW:0]             factor_eff;
  logic [PW:0]             phase_inc;
  logic                    emit;
  logic                    accept;
  logic                    busy;
  logic                    pass_active;
  logic [CAW-1:0]          step;
  logic [FW-1:0]           coef_addr;
  logic [COEF_WIDTH-1:0]   coef_rdata;

  logic signed [SAMPLE_WIDTH-1:0] new_im;
  logic signed [SAMPLE_WIDTH-1:0] tap_re [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] tap_im [MAX_TAPS];
  dfc_cell_ctrl_t          cell_ctrl;
  dfc_mac_ctrl_t           mac_ctrl;
  logic                    mac_valid;
  dfc_result_t             mac_res;
  logic                    take;

  // configuration port
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign coef_we = wr_en && (reg_idx == REG_COEF_VALUE) && (int'(coef_index) < MAX_TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAP_COUNT_RST;
      decim_factor <= FACTOR_RST;
      complex_mode <= 1'b0;
      coef_index   <= '0;
      coef_value   <= '0;
      out_shift    <= SHIFT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TAP_COUNT:    tap_count    <= pwdata[TAP_COUNT_W-1:0];
        REG_DECIM_FACTOR: decim_factor <= pwdata[FACTOR_W-1:0];
        REG_COMPLEX_MODE: complex_mode <= pwdata[0];
        REG_COEF_INDEX:   coef_index   <= pwdata[COEF_INDEX_W-1:0];
        REG_COEF_VALUE:   coef_value   <= pwdata[COEF_WIDTH-1:0];
        REG_OUT_SHIFT:    out_shift    <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TAP_COUNT:    prdata = APB_DATA_W'(tap_count);
      REG_DECIM_FACTOR: prdata = APB_DATA_W'(decim_factor);
      REG_COMPLEX_MODE: prdata = APB_DATA_W'(complex_mode);
      REG_COEF_INDEX:   prdata = APB_DATA_W'(coef_index);
      REG_COEF_VALUE:   prdata = APB_DATA_W'(coef_value);
      REG_OUT_SHIFT:    prdata = APB_DATA_W'(out_shift);
      default:          prdata = '0;
    endcase
  end

  // effective tap count and factor
  always_comb begin
    if (tap_count == '0) begin
      taps_eff = FW'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      taps_eff = FW'(MAX_TAPS);
    end else begin
      taps_eff = FW'(tap_count);
    end
    if (decim_factor == '0) begin
      factor_eff = (PW+1)'(1);
    end else if (int'(decim_factor) > MAX_FACTOR) begin
      factor_eff = (PW+1)'(MAX_FACTOR);
    end else begin
      factor_eff = (PW+1)'(decim_factor);
    end
  end

  // fill and decimation phase
  assign phase_inc = {1'b0, phase_count} + (PW+1)'(1);

  always_comb begin
    fill_count_next  = fill_count;
    phase_count_next = phase_count;
    emit             = 1'b0;
    if (fill_count < taps_eff) begin
      fill_count_next = fill_count + FW'(1);
      if (fill_count_next >= taps_eff) begin
        emit             = 1'b1;
        phase_count_next = '0;
      end
    end else if (phase_inc >= factor_eff) begin
      emit             = 1'b1;
      phase_count_next = '0;
    end else begin
      phase_count_next = phase_inc[PW-1:0];
    end
  end

  assign sample_stall = busy;
  assign accept       = sample_valid & ~busy;
  assign take         = mac_valid & (~result_valid | ~result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      phase_count  <= '0;
      busy         <= 1'b0;
      pass_active  <= 1'b0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill_count  <= fill_count_next;
        phase_count <= phase_count_next;
      end
      if (accept && emit) begin
        busy        <= 1'b1;
        pass_active <= 1'b1;
        step        <= '0;
      end else if (pass_active) begin
        step <= step + CAW'(1);
        if (step == CAW'(MAX_TAPS - 1)) begin
          pass_active <= 1'b0;
        end
      end
      if (take) begin
        busy         <= 1'b0;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= mac_res;
    end
  end

  // tap chain
  assign new_im           = complex_mode ? sample.sample_im : '0;
  assign cell_ctrl.shift  = accept;
  assign cell_ctrl.rotate = pass_active;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    if (k == 0) begin : g_head
      dfc_tap_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .left_re  (sample.sample_re),
        .left_im  (new_im),
        .right_re (tap_re[(k + 1) % MAX_TAPS]),
        .right_im (tap_im[(k + 1) % MAX_TAPS]),
        .tap_re   (tap_re[k]),
        .tap_im   (tap_im[k])
      );
    end else begin : g_body
      dfc_tap_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .left_re  (tap_re[k - 1]),
        .left_im  (tap_im[k - 1]),
        .right_re (tap_re[(k + 1) % MAX_TAPS]),
        .right_im (tap_im[(k + 1) % MAX_TAPS]),
        .tap_re   (tap_re[k]),
        .tap_im   (tap_im[k])
      );
    end
  end

  // head cell holds the sample of age step; it pairs with slot taps-1-step
  assign coef_addr      = taps_eff - FW'(1) - FW'(step);
  assign mac_ctrl.clear = accept & emit;
  assign mac_ctrl.vld   = pass_active && (FW'(step) < taps_eff);
  assign mac_ctrl.last  = pass_active && (step == CAW'(MAX_TAPS - 1));

  dfc_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CAW'(coef_index)),
    .wdata (pwdata[COEF_WIDTH-1:0]),
    .raddr (coef_addr[CAW-1:0]),
    .rdata (coef_rdata)
  );

  dfc_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (mac_ctrl),
    .head_re      (tap_re[0]),
    .head_im      (tap_im[0]),
    .coef         ($signed(coef_rdata)),
    .out_shift    (out_shift),
    .complex_mode (complex_mode),
    .take         (take),
    .res_valid    (mac_valid),
    .res          (mac_res)
  );

endmodule

[hw/rtl/dfc_ram.sv]
// ----------------------------------------------------------------------------
// dfc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [dfc_pkg::addr_w(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [dfc_pkg::addr_w(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dfc_tap_cell.sv]
// ----------------------------------------------------------------------------
// dfc_tap_cell: one tap of the delay line
// Holds one I/Q sample; takes its left neighbour on a shift and its right
// neighbour on a rotation.
// ----------------------------------------------------------------------------
module dfc_tap_cell (
  input  logic                                  clk,
  input  dfc_pkg::dfc_cell_ctrl_t               ctrl,
  input  logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] left_re,
  input  logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] left_im,
  input  logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] right_re,
  input  logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] right_im,
  output logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] tap_re,
  output logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] tap_im
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      tap_re <= left_re;
      tap_im <= left_im;
    end else if (ctrl.rotate) begin
      tap_re <= right_re;
      tap_im <= right_im;
    end
  end

endmodule

[hw/rtl/dfc_mac.sv]
// ----------------------------------------------------------------------------
// dfc_mac: multiply-accumulate and output scaling
// Multiplies the head tap by its coefficient, accumulates both parts, then
// rounds, shifts and saturates. The result is held until taken.
// ----------------------------------------------------------------------------
module dfc_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  dfc_pkg::dfc_mac_ctrl_t                  ctrl,
  input  logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] head_re,
  input  logic signed [dfc_pkg::SAMPLE_WIDTH-1:0] head_im,
  input  logic signed [dfc_pkg::COEF_WIDTH-1:0]   coef,
  input  logic [dfc_pkg::SHIFT_W-1:0]             out_shift,
  input  logic                                    complex_mode,
  input  logic                                    take,
  output logic                                    res_valid,
  output dfc_pkg::dfc_result_t                    res
);
  import dfc_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ACC_HI = ACC_WIDTH'(SAMPLE_MAX);
  localparam logic signed [ACC_WIDTH-1:0] ACC_LO = ACC_WIDTH'(SAMPLE_MIN);

  logic signed [SAMPLE_WIDTH-1:0] s1_re, s1_im;
  logic                           s1_vld, s1_last;
  logic signed [PROD_WIDTH-1:0]   p_re, p_im;
  logic                           p_vld, p_last;
  logic signed [ACC_WIDTH-1:0]    acc_re, acc_im;
  logic                           a_done;
  logic signed [ACC_WIDTH-1:0]    r_re, r_im;
  logic                           r_vld;
  logic signed [ACC_WIDTH-1:0]    rnd;
  logic signed [ACC_WIDTH-1:0]    sh_re, sh_im;
  logic [SAMPLE_WIDTH:0]          sat_re, sat_im;

  // {clip, value}
  function automatic logic [SAMPLE_WIDTH:0] saturate(input logic signed [ACC_WIDTH-1:0] v);
    logic [SAMPLE_WIDTH:0] r;
    if (v > ACC_HI) begin
      r = {1'b1, SAMPLE_MAX};
    end else if (v < ACC_LO) begin
      r = {1'b1, SAMPLE_MIN};
    end else begin
      r = {1'b0, v[SAMPLE_WIDTH-1:0]};
    end
    return r;
  endfunction

  assign rnd   = (out_shift == '0) ? '0 : (ACC_WIDTH'(1) <<< (out_shift - SHIFT_W'(1)));
  assign sh_re = r_re >>> out_shift;
  assign sh_im = r_im >>> out_shift;

  always_comb begin
    sat_re = saturate(sh_re);
    sat_im = saturate(sh_im);
  end

  always_ff @(posedge clk) begin
    s1_re <= head_re;
    s1_im <= head_im;
    p_re  <= PROD_WIDTH'(s1_re) * PROD_WIDTH'(coef);
    p_im  <= PROD_WIDTH'(s1_im) * PROD_WIDTH'(coef);
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (p_vld) begin
      acc_re <= acc_re + ACC_WIDTH'(p_re);
      acc_im <= acc_im + ACC_WIDTH'(p_im);
    end
    if (a_done) begin
      r_re <= acc_re + rnd;
      r_im <= acc_im + rnd;
    end
    if (r_vld) begin
      res.out_re    <= sat_re[SAMPLE_WIDTH-1:0];
      res.out_im    <= complex_mode ? sat_im[SAMPLE_WIDTH-1:0] : '0;
      res.saturated <= sat_re[SAMPLE_WIDTH] | (complex_mode & sat_im[SAMPLE_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s1_last   <= 1'b0;
      p_vld     <= 1'b0;
      p_last    <= 1'b0;
      a_done    <= 1'b0;
      r_vld     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_vld  <= ctrl.vld;
      s1_last <= ctrl.last;
      p_vld   <= s1_vld;
      p_last  <= s1_last;
      a_done  <= p_last;
      r_vld   <= a_done;
      if (r_vld) begin
        res_valid <= 1'b1;
      end else if (take) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/dfc_checker.sv]
// ----------------------------------------------------------------------------
// dfc_checker: port-level checks of the decimating FIR filter
// Attached to the top level by a bind statement at the end of this file.
// ----------------------------------------------------------------------------
module dfc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              sample_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input dfc_pkg::dfc_result_t              result
);
  import dfc_pkg::*;

  // a stalled result request holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result request changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("reset left a request or stall pending");

  // a new result only follows a computing period
  a_result_after_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared without a computing period");

  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(sample_stall) |-> result_valid)
    else $error("stall released without a result");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      (result.out_re == SAMPLE_MAX || result.out_re == SAMPLE_MIN ||
       result.out_im == SAMPLE_MAX || result.out_im == SAMPLE_MIN))
    else $error("saturated flag without a clipped value");

endmodule

bind decimating_fir_filter_core dfc_checker u_dfc_checker (.*);
